// File: rtl/hlsrgb_pkg.sv
// ----------------------------------------------------------------------------
// hlsrgb_pkg
// Shared widths, constants, types and the hue ramp position function of the
// HLS to RGB converter.
// ----------------------------------------------------------------------------
package hlsrgb_pkg;

	// field widths
	localparam int unsigned HUE_W = 12;
	localparam int unsigned LIG_W = 10;
	localparam int unsigned SAT_W = 10;
	localparam int unsigned CH_W  = 16;

	// internal widths
	localparam int unsigned LS_W    = LIG_W + SAT_W;   // lightness * saturation
	localparam int unsigned M_W     = 24;              // m1, m2, m2 - m1 (signed)
	localparam int unsigned X_W     = 14;              // hue position (signed)
	localparam int unsigned T_W     = 10;              // ramp position 0..600
	localparam int unsigned V_W     = 36;              // channel numerator (signed)
	localparam int unsigned FRAC_W  = 30;              // reciprocal scale, bits of v
	localparam int unsigned RECIP_W = 17;
	localparam int unsigned PROD_W  = FRAC_W + RECIP_W;

	// hue geometry in tenths of a degree
	localparam logic signed [X_W-1:0] HUE_OFS   = 14'sd1200;
	localparam logic signed [X_W-1:0] HUE_FULL  = 14'sd3600;
	localparam logic signed [X_W-1:0] SEG_RISE  = 14'sd600;
	localparam logic signed [X_W-1:0] SEG_HOLD  = 14'sd1800;
	localparam logic signed [X_W-1:0] SEG_FALL  = 14'sd2400;

	// bounds arithmetic
	localparam logic [LIG_W-1:0]      L_HALF      = 10'd500;
	localparam logic signed [M_W-1:0] MILLI       = 24'sd1000;
	localparam logic signed [M_W-1:0] TWO_MILLI   = 24'sd2000;

	// channel scaling: ch = trunc(65535 * v / 6e8)
	localparam logic signed [V_W-1:0]  RAMP_LEN   = 36'sd600;
	localparam logic signed [V_W-1:0]  GRAY_SCALE = 36'sd600000;
	localparam logic signed [V_W-1:0]  RAMP_DEN_S = 36'sd600000000;
	localparam logic [PROD_W-1:0]      RAMP_DEN   = 47'd600000000;
	localparam logic [PROD_W-1:0]      CH_FULL    = 47'd65535;
	localparam logic [PROD_W-1:0]      RECIP      = 47'd117279;  // floor(2^30*65535/6e8)
	localparam logic [CH_W-1:0]        CH_MAX     = 16'hFFFF;

	// input color class
	typedef struct packed {
		logic achrom;   // saturation is zero
		logic undef;    // hue undefined
	} mode_t;

	// per-stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} pipe_en_t;

	// Wrap a hue position once and map it onto the ramp: 0 gives m1, 600 gives m2.
	function automatic logic [T_W-1:0] ramp_pos(input logic signed [X_W-1:0] x_in);
		logic signed [X_W-1:0] x;
		logic signed [X_W-1:0] t;
		x = x_in;
		if (x > HUE_FULL) begin
			x = x - HUE_FULL;
		end
		if (x < 0) begin
			x = x + HUE_FULL;
		end
		if (x < SEG_RISE) begin
			t = x;
		end else if (x < SEG_HOLD) begin
			t = SEG_RISE;
		end else if (x < SEG_FALL) begin
			t = SEG_FALL - x;
		end else begin
			t = '0;
		end
		return t[T_W-1:0];
	endfunction

endpackage

// File: rtl/hlsrgb_bounds.sv
// ----------------------------------------------------------------------------
// hlsrgb_bounds
// Stages 1 and 2: lightness * saturation product and ramp positions, then
// the bounds m1 and the slope m2 - m1.
// ----------------------------------------------------------------------------
module hlsrgb_bounds (
	input  logic                             clk,
	input  hlsrgb_pkg::pipe_en_t             en,
	input  logic [hlsrgb_pkg::HUE_W-1:0]     hue_tenths,
	input  logic                             hue_undefined,
	input  logic [hlsrgb_pkg::LIG_W-1:0]     lightness_milli,
	input  logic [hlsrgb_pkg::SAT_W-1:0]     saturation_milli,
	output logic signed [hlsrgb_pkg::M_W-1:0] m1_s2,
	output logic signed [hlsrgb_pkg::M_W-1:0] slope_s2,
	output logic [hlsrgb_pkg::T_W-1:0]       t_r_s2,
	output logic [hlsrgb_pkg::T_W-1:0]       t_g_s2,
	output logic [hlsrgb_pkg::T_W-1:0]       t_b_s2,
	output hlsrgb_pkg::mode_t                mode_s2,
	output logic [hlsrgb_pkg::LIG_W-1:0]     lig_s2
);

	logic signed [hlsrgb_pkg::X_W-1:0] hue_x;
	logic [hlsrgb_pkg::LS_W-1:0]       ls_s1;
	logic [hlsrgb_pkg::LIG_W-1:0]      lig_s1;
	logic [hlsrgb_pkg::SAT_W-1:0]      sm_s1;
	logic                              lo_s1;
	hlsrgb_pkg::mode_t                 mode_s1;
	logic [hlsrgb_pkg::T_W-1:0]        t_r_s1;
	logic [hlsrgb_pkg::T_W-1:0]        t_g_s1;
	logic [hlsrgb_pkg::T_W-1:0]        t_b_s1;

	logic signed [hlsrgb_pkg::M_W-1:0] l_x;
	logic signed [hlsrgb_pkg::M_W-1:0] s_x;
	logic signed [hlsrgb_pkg::M_W-1:0] ls_x;
	logic signed [hlsrgb_pkg::M_W-1:0] m2;
	logic signed [hlsrgb_pkg::M_W-1:0] m1;

	assign hue_x = $signed({{(hlsrgb_pkg::X_W-hlsrgb_pkg::HUE_W){1'b0}}, hue_tenths});

	// stage 1: product, ramp positions for red (+120), green, blue (-120)
	always_ff @(posedge clk) begin
		if (en.s1) begin
			ls_s1   <= hlsrgb_pkg::LS_W'(lightness_milli) * hlsrgb_pkg::LS_W'(saturation_milli);
			lig_s1  <= lightness_milli;
			sm_s1   <= saturation_milli;
			lo_s1   <= (lightness_milli < hlsrgb_pkg::L_HALF);
			mode_s1 <= '{achrom: (saturation_milli == '0), undef: hue_undefined};
			t_r_s1  <= hlsrgb_pkg::ramp_pos(hue_x + hlsrgb_pkg::HUE_OFS);
			t_g_s1  <= hlsrgb_pkg::ramp_pos(hue_x);
			t_b_s1  <= hlsrgb_pkg::ramp_pos(hue_x - hlsrgb_pkg::HUE_OFS);
		end
	end

	// m2, m1 in millionths
	assign l_x  = $signed({{(hlsrgb_pkg::M_W-hlsrgb_pkg::LIG_W){1'b0}}, lig_s1});
	assign s_x  = $signed({{(hlsrgb_pkg::M_W-hlsrgb_pkg::SAT_W){1'b0}}, sm_s1});
	assign ls_x = $signed({{(hlsrgb_pkg::M_W-hlsrgb_pkg::LS_W){1'b0}}, ls_s1});
	assign m2   = lo_s1 ? (hlsrgb_pkg::MILLI * l_x + ls_x)
	                    : (hlsrgb_pkg::MILLI * l_x + hlsrgb_pkg::MILLI * s_x - ls_x);
	assign m1   = hlsrgb_pkg::TWO_MILLI * l_x - m2;

	// stage 2
	always_ff @(posedge clk) begin
		if (en.s2) begin
			m1_s2    <= m1;
			slope_s2 <= m2 - m1;
			t_r_s2   <= t_r_s1;
			t_g_s2   <= t_g_s1;
			t_b_s2   <= t_b_s1;
			mode_s2  <= mode_s1;
			lig_s2   <= lig_s1;
		end
	end

endmodule

// File: rtl/hlsrgb_lane.sv
// ----------------------------------------------------------------------------
// hlsrgb_lane
// Stages 3 to 6 of one color channel: ramp value, range check, reciprocal
// divide by 6e8 with a one-step correction, and the saturated result.
// ----------------------------------------------------------------------------
module hlsrgb_lane (
	input  logic                              clk,
	input  hlsrgb_pkg::pipe_en_t              en,
	input  logic signed [hlsrgb_pkg::M_W-1:0] m1,
	input  logic signed [hlsrgb_pkg::M_W-1:0] slope,
	input  logic [hlsrgb_pkg::T_W-1:0]        t,
	input  hlsrgb_pkg::mode_t                 mode,
	input  logic [hlsrgb_pkg::LIG_W-1:0]      lig,
	output logic [hlsrgb_pkg::CH_W-1:0]       ch_s6
);

	logic signed [hlsrgb_pkg::V_W-1:0] m1_x;
	logic signed [hlsrgb_pkg::V_W-1:0] slope_x;
	logic signed [hlsrgb_pkg::V_W-1:0] t_x;

	logic signed [hlsrgb_pkg::V_W-1:0] base_s3;
	logic signed [hlsrgb_pkg::V_W-1:0] rise_s3;
	hlsrgb_pkg::mode_t                 mode_s3;
	logic [hlsrgb_pkg::LIG_W-1:0]      lig_s3;

	logic signed [hlsrgb_pkg::V_W-1:0] lig_x;
	logic signed [hlsrgb_pkg::V_W-1:0] v;
	logic [hlsrgb_pkg::FRAC_W-1:0]     v_s4;
	logic                              neg_s4;
	logic                              sat_s4;

	logic [hlsrgb_pkg::PROD_W-1:0]     est;
	logic [hlsrgb_pkg::CH_W-1:0]       q0_s5;
	logic [hlsrgb_pkg::FRAC_W-1:0]     v_s5;
	logic                              neg_s5;
	logic                              sat_s5;

	logic [hlsrgb_pkg::PROD_W-1:0]     next_num;
	logic [hlsrgb_pkg::PROD_W-1:0]     scaled;
	logic                              bump;

	assign m1_x    = $signed({{(hlsrgb_pkg::V_W-hlsrgb_pkg::M_W){m1[hlsrgb_pkg::M_W-1]}}, m1});
	assign slope_x = $signed({{(hlsrgb_pkg::V_W-hlsrgb_pkg::M_W){slope[hlsrgb_pkg::M_W-1]}},
	                          slope});
	assign t_x     = $signed({{(hlsrgb_pkg::V_W-hlsrgb_pkg::T_W){1'b0}}, t});

	// stage 3: 600*m1 and (m2 - m1)*t
	always_ff @(posedge clk) begin
		if (en.s3) begin
			base_s3 <= m1_x * hlsrgb_pkg::RAMP_LEN;
			rise_s3 <= slope_x * t_x;
			mode_s3 <= mode;
			lig_s3  <= lig;
		end
	end

	// stage 4: numerator, gray or black for achromatic colors
	assign lig_x = $signed({{(hlsrgb_pkg::V_W-hlsrgb_pkg::LIG_W){1'b0}}, lig_s3});

	always_comb begin
		if (mode_s3.achrom) begin
			v = mode_s3.undef ? (lig_x * hlsrgb_pkg::GRAY_SCALE) : '0;
		end else begin
			v = base_s3 + rise_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			v_s4   <= v[hlsrgb_pkg::FRAC_W-1:0];
			neg_s4 <= v[hlsrgb_pkg::V_W-1];
			sat_s4 <= (v >= hlsrgb_pkg::RAMP_DEN_S);
		end
	end

	// stage 5: quotient estimate, low by at most one
	assign est = {{hlsrgb_pkg::RECIP_W{1'b0}}, v_s4} * hlsrgb_pkg::RECIP;

	always_ff @(posedge clk) begin
		if (en.s5) begin
			q0_s5  <= est[hlsrgb_pkg::FRAC_W +: hlsrgb_pkg::CH_W];
			v_s5   <= v_s4;
			neg_s5 <= neg_s4;
			sat_s5 <= sat_s4;
		end
	end

	// stage 6: correct the estimate, then clamp
	assign next_num = ({{(hlsrgb_pkg::PROD_W-hlsrgb_pkg::CH_W){1'b0}}, q0_s5} + 1'b1)
	                  * hlsrgb_pkg::RAMP_DEN;
	assign scaled   = {{hlsrgb_pkg::RECIP_W{1'b0}}, v_s5} * hlsrgb_pkg::CH_FULL;
	assign bump     = (next_num <= scaled);

	always_ff @(posedge clk) begin
		if (en.s6) begin
			if (neg_s5) begin
				ch_s6 <= '0;
			end else if (sat_s5) begin
				ch_s6 <= hlsrgb_pkg::CH_MAX;
			end else begin
				ch_s6 <= q0_s5 + hlsrgb_pkg::CH_W'(bump);
			end
		end
	end

endmodule

// File: rtl/hls_to_rgb_converter_core.sv
// Path: an accepted input beat passes through stages s1 to s6 to the output.
// Throughput: one beat per cycle while out_ready is high; six register stages,
// each holds one beat and moves up whenever the next stage is empty or moving.
// Reset: arst_n clears all stage valid bits asynchronously; data is not reset.
// ----------------------------------------------------------------------------
// hls_to_rgb_converter_core
// HLS to 16-bit RGB converter: shared bounds stages feed three channel lanes.
// ----------------------------------------------------------------------------
module hls_to_rgb_converter_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [hlsrgb_pkg::HUE_W-1:0] hue_tenths,
	input  logic                         hue_undefined,
	input  logic [hlsrgb_pkg::LIG_W-1:0] lightness_milli,
	input  logic [hlsrgb_pkg::SAT_W-1:0] saturation_milli,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [hlsrgb_pkg::CH_W-1:0]  red,
	output logic [hlsrgb_pkg::CH_W-1:0]  green,
	output logic [hlsrgb_pkg::CH_W-1:0]  blue
);

	hlsrgb_pkg::pipe_en_t              en;
	logic                              v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [hlsrgb_pkg::M_W-1:0] m1_s2;
	logic signed [hlsrgb_pkg::M_W-1:0] slope_s2;
	logic [hlsrgb_pkg::T_W-1:0]        t_r_s2;
	logic [hlsrgb_pkg::T_W-1:0]        t_g_s2;
	logic [hlsrgb_pkg::T_W-1:0]        t_b_s2;
	hlsrgb_pkg::mode_t                 mode_s2;
	logic [hlsrgb_pkg::LIG_W-1:0]      lig_s2;

	// a stage loads when it is empty or its beat moves on
	assign en.s6 = !v_s6 || out_ready;
	assign en.s5 = !v_s5 || en.s6;
	assign en.s4 = !v_s4 || en.s5;
	assign en.s3 = !v_s3 || en.s4;
	assign en.s2 = !v_s2 || en.s3;
	assign en.s1 = !v_s1 || en.s2;

	assign in_ready  = en.s1;
	assign out_valid = v_s6;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= in_valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4;
			if (en.s6) v_s6 <= v_s5;
		end
	end

	// shared bounds
	hlsrgb_bounds u_bounds (
		.clk              (clk),
		.en               (en),
		.hue_tenths       (hue_tenths),
		.hue_undefined    (hue_undefined),
		.lightness_milli  (lightness_milli),
		.saturation_milli (saturation_milli),
		.m1_s2            (m1_s2),
		.slope_s2         (slope_s2),
		.t_r_s2           (t_r_s2),
		.t_g_s2           (t_g_s2),
		.t_b_s2           (t_b_s2),
		.mode_s2          (mode_s2),
		.lig_s2           (lig_s2)
	);

	// channel lanes
	hlsrgb_lane u_lane_r (
		.clk   (clk),
		.en    (en),
		.m1    (m1_s2),
		.slope (slope_s2),
		.t     (t_r_s2),
		.mode  (mode_s2),
		.lig   (lig_s2),
		.ch_s6 (red)
	);

	hlsrgb_lane u_lane_g (
		.clk   (clk),
		.en    (en),
		.m1    (m1_s2),
		.slope (slope_s2),
		.t     (t_g_s2),
		.mode  (mode_s2),
		.lig   (lig_s2),
		.ch_s6 (green)
	);

	hlsrgb_lane u_lane_b (
		.clk   (clk),
		.en    (en),
		.m1    (m1_s2),
		.slope (slope_s2),
		.t     (t_b_s2),
		.mode  (mode_s2),
		.lig   (lig_s2),
		.ch_s6 (blue)
	);

endmodule
